// ===== hdl/mted_pkg.sv =====
// ----------------------------------------------------------------------------
// mted_pkg: shared types and constants for the multi-tap echo delay
// Field widths, register map, saturation limits and the microcode table
// that sequences one sample through the tap loop.
// ----------------------------------------------------------------------------
package mted_pkg;

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int SPACING_W = 16;
  localparam int COUNT_W   = 5;

  // Parameter defaults
  localparam int DEPTH_DEF    = 32768;
  localparam int MAX_TAPS_DEF = 16;

  // Register reset values
  localparam logic [SPACING_W-1:0] SPACING_RST = 16'd4800;
  localparam logic [COUNT_W-1:0]   COUNT_RST   = 5'd1;

  // Wet sum saturation limits
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -24'sh800000;

  // Register map, 32-bit registers at 4-byte spacing
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TAP_SPACING    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALT_POLARITY   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LINEAR_DIVISOR = 2'd3;

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Microprogram step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;  // wait for input transfer
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;  // all taps done?
  localparam logic [STEP_W-1:0] STEP_READ  = 3'd2;  // delay line read
  localparam logic [STEP_W-1:0] STEP_DLOAD = 3'd3;  // load divider
  localparam logic [STEP_W-1:0] STEP_DSTEP = 3'd4;  // divider iteration
  localparam logic [STEP_W-1:0] STEP_ACC   = 3'd5;  // accumulate tap term
  localparam logic [STEP_W-1:0] STEP_FWAIT = 3'd6;  // wait for free output reg
  localparam logic [STEP_W-1:0] STEP_WRITE = 3'd7;  // emit result, store sample

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_TAPS_DONE,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_e;

  // One control word
  typedef struct packed {
    logic              load;   // capture input sample, clear wet sum
    logic              rd;     // issue delay line read, pick tap source
    logic              dload;  // load divider operands
    logic              dstep;  // one divider iteration
    logic              acc;    // add signed term, advance tap
    logic              emit;   // load output reg, write delay line
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Microcode ROM
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_WAIT;
    case (step)
      STEP_WAIT: begin
        w.load   = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_WAIT;
      end
      STEP_CHECK: begin
        w.cond   = COND_TAPS_DONE;
        w.target = STEP_FWAIT;
      end
      STEP_READ: begin
        w.rd = 1'b1;
      end
      STEP_DLOAD: begin
        w.dload = 1'b1;
      end
      STEP_DSTEP: begin
        w.dstep  = 1'b1;
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_DSTEP;
      end
      STEP_ACC: begin
        w.acc    = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_CHECK;
      end
      STEP_FWAIT: begin
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_FWAIT;
      end
      STEP_WRITE: begin
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/multi_tap_echo_delay.sv =====
// ----------------------------------------------------------------------------
// multi_tap_echo_delay: microcoded multi-tap echo over a sample delay line
// Sums up to MAX_TAPS scaled echo taps, saturates, mixes with the dry input.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / sample_in_i) takes one signed
//   24-bit sample per transfer; output channel (out_valid_o / out_stall_i /
//   sample_out_o) returns one mixed sample per input, in order.
//   The user must write the registers through the APB port only while the
//   block is idle; the block itself does not enforce it. A sequencer walks
//   the taps one after another: for each it reads the delay line, loads the
//   divider (a shift by the tap index with power-of-two scaling), runs the
//   bit-serial divider with the linear divisor, and adds the term. The next
//   input is taken only after the previous result is loaded into the output reg.
//   The output register holds a finished result while the next sample is
//   processed; if it is still stalled when that sample is done, the
//   sequencer waits until it drains.
//   Reset clears the registers to their defaults and the fill count to zero;
//   taps that reach past the samples written since reset read zero, so the
//   delay memory needs no clearing pass and the block is ready at once.
// ----------------------------------------------------------------------------
module multi_tap_echo_delay #(
  parameter int DEPTH    = mted_pkg::DEPTH_DEF,
  parameter int MAX_TAPS = mted_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mted_pkg::SAMPLE_W-1:0] sample_in_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mted_pkg::SAMPLE_W-1:0] sample_out_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mted_pkg::PADDR_W-1:0]        paddr,
  input  logic [mted_pkg::PDATA_W-1:0]        pwdata,
  output logic [mted_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int SW     = mted_pkg::SAMPLE_W;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AW1    = ADDR_W + 1;                      // fill count / delay math
  localparam int K_W    = $clog2(MAX_TAPS + 2);            // tap index, divisor
  localparam int DLY_W  = mted_pkg::SPACING_W + $clog2(MAX_TAPS + 1);
  localparam int CMP_W  = (DLY_W > AW1) ? DLY_W : AW1;
  localparam int CW     = (K_W > mted_pkg::COUNT_W) ? K_W : mted_pkg::COUNT_W;
  localparam int WET_W  = SW + $clog2(MAX_TAPS + 1);

  // Tap source codes
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_CUR  = 2'd1;
  localparam logic [1:0] SRC_MEM  = 2'd2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mted_pkg::SPACING_W-1:0] spacing_q;
  logic [mted_pkg::COUNT_W-1:0]   count_q;
  logic                           alt_q;
  logic                           lin_q;
  logic                           cfg_wr;
  logic [mted_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[mted_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= mted_pkg::SPACING_RST;
      count_q   <= mted_pkg::COUNT_RST;
      alt_q     <= 1'b0;
      lin_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mted_pkg::REG_TAP_SPACING:    spacing_q <= pwdata[mted_pkg::SPACING_W-1:0];
        mted_pkg::REG_TAP_COUNT:      count_q   <= pwdata[mted_pkg::COUNT_W-1:0];
        mted_pkg::REG_ALT_POLARITY:   alt_q     <= pwdata[0];
        mted_pkg::REG_LINEAR_DIVISOR: lin_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      mted_pkg::REG_TAP_SPACING:    prdata = mted_pkg::PDATA_W'(spacing_q);
      mted_pkg::REG_TAP_COUNT:      prdata = mted_pkg::PDATA_W'(count_q);
      mted_pkg::REG_ALT_POLARITY:   prdata = mted_pkg::PDATA_W'(alt_q);
      mted_pkg::REG_LINEAR_DIVISOR: prdata = mted_pkg::PDATA_W'(lin_q);
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [mted_pkg::STEP_W-1:0] upc_q, upc_d;
  mted_pkg::ctrl_word_t        cw;
  logic                        jump;
  logic                        in_xfer;
  logic                        taps_done;
  logic                        div_busy;
  logic                        out_busy;

  logic [K_W-1:0]              k_q;
  logic [mted_pkg::DCNT_W-1:0] dcnt_q;
  logic                        out_valid_q;
  logic [CW-1:0]               taps_eff;

  assign cw         = mted_pkg::ucode_rom(upc_q);
  assign in_stall_o = (upc_q != mted_pkg::STEP_WAIT);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // Tap count saturates at MAX_TAPS
  assign taps_eff  = (CW'(count_q) > CW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(count_q);
  assign taps_done = (CW'(k_q) > taps_eff);
  assign div_busy  = (dcnt_q > mted_pkg::DCNT_W'(1));
  assign out_busy  = out_valid_q & out_stall_i;

  always_comb begin
    case (cw.cond)
      mted_pkg::COND_NEVER:     jump = 1'b0;
      mted_pkg::COND_ALWAYS:    jump = 1'b1;
      mted_pkg::COND_NO_INPUT:  jump = ~in_valid_i;
      mted_pkg::COND_TAPS_DONE: jump = taps_done;
      mted_pkg::COND_DIV_BUSY:  jump = div_busy;
      mted_pkg::COND_OUT_BUSY:  jump = out_busy;
      default:                  jump = 1'b1;
    endcase
    upc_d = jump ? cw.target : upc_q + mted_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= mted_pkg::STEP_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Tap index and delay
  // --------------------------------------------------------------------------
  logic [DLY_W-1:0] delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      delay_q <= '0;
    end else if (cw.load && in_xfer) begin
      k_q     <= K_W'(1);
      delay_q <= DLY_W'(spacing_q);
    end else if (cw.acc) begin
      k_q     <= k_q + K_W'(1);
      delay_q <= delay_q + DLY_W'(spacing_q);
    end
  end

  // --------------------------------------------------------------------------
  // Delay line: write pointer, fill count, memory
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]   wi_q;
  logic [AW1-1:0]      fill_q;
  logic signed [SW-1:0] x_q;
  logic signed [SW-1:0] mem [DEPTH];
  logic signed [SW-1:0] mem_rd_q;
  logic [AW1-1:0]      dly_a;
  logic [AW1-1:0]      rd_pos;
  logic [1:0]          src_d, src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      fill_q <= '0;
    end else if (cw.emit) begin
      wi_q <= (wi_q == ADDR_W'(DEPTH - 1)) ? '0 : wi_q + ADDR_W'(1);
      if (fill_q != AW1'(DEPTH)) begin
        fill_q <= fill_q + AW1'(1);
      end
    end
  end

  // Read address: write pointer minus delay, wrapped once
  assign dly_a  = AW1'(CMP_W'(delay_q));
  assign rd_pos = {1'b0, wi_q} + (({1'b0, wi_q} < dly_a) ? AW1'(DEPTH) : '0) - dly_a;

  // Tap source: current input, stored sample, or zero past the fill
  always_comb begin
    if (delay_q == '0) begin
      src_d = SRC_CUR;
    end else if (CMP_W'(delay_q) <= CMP_W'(fill_q)) begin
      src_d = SRC_MEM;
    end else begin
      src_d = SRC_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.emit) begin
      mem[wi_q] <= x_q;
    end
    if (cw.rd) begin
      mem_rd_q <= mem[rd_pos[ADDR_W-1:0]];
      src_q    <= src_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: sign/magnitude, bit-serial restoring or shift for 2^k
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] tap_s;
  logic                 tap_neg;
  logic [SW-1:0]        tap_mag;
  logic [SW-1:0]        quo_q;
  logic [K_W-1:0]       rem_q;
  logic [K_W-1:0]       dvs_q;
  logic                 neg_q;
  logic [K_W:0]         rem_sh;
  logic                 rem_ge;

  always_comb begin
    case (src_q)
      SRC_CUR: tap_s = x_q;
      SRC_MEM: tap_s = mem_rd_q;
      default: tap_s = '0;
    endcase
  end

  assign tap_neg = tap_s[SW-1];
  assign tap_mag = tap_neg ? (~tap_s + SW'(1)) : tap_s;
  assign rem_sh  = {rem_q, quo_q[SW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cw.dload) begin
      dcnt_q <= lin_q ? mted_pkg::DCNT_W'(mted_pkg::DIV_STEPS) : '0;
    end else if (cw.dstep && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - mted_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.dload) begin
      neg_q <= tap_neg ^ (alt_q & k_q[0]);
      rem_q <= '0;
      dvs_q <= k_q + K_W'(1);
      quo_q <= lin_q ? tap_mag : (tap_mag >> k_q);
    end else if (cw.dstep && dcnt_q != '0) begin
      quo_q <= {quo_q[SW-2:0], rem_ge};
      rem_q <= rem_ge ? K_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[K_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Wet accumulator, saturation and dry/wet mix
  // --------------------------------------------------------------------------
  logic signed [WET_W-1:0] wet_q;
  logic signed [WET_W-1:0] term;
  logic signed [SW-1:0]    wet_sat;
  logic signed [SW:0]      mix_sum;
  logic signed [SW:0]      mix_rnd;
  logic signed [SW-1:0]    out_q;

  assign term = {{(WET_W - SW){1'b0}}, quo_q};

  always_ff @(posedge clk_i) begin
    if (cw.load && in_xfer) begin
      x_q   <= sample_in_i;
      wet_q <= '0;
    end else if (cw.acc) begin
      wet_q <= neg_q ? (wet_q - term) : (wet_q + term);
    end
  end

  always_comb begin
    if (wet_q > WET_W'(mted_pkg::SAT_MAX)) begin
      wet_sat = mted_pkg::SAT_MAX;
    end else if (wet_q < WET_W'(mted_pkg::SAT_MIN)) begin
      wet_sat = mted_pkg::SAT_MIN;
    end else begin
      wet_sat = wet_q[SW-1:0];
    end
  end

  // Halve with truncation toward zero: add one before the shift if negative
  assign mix_sum = {x_q[SW-1], x_q} + {wet_sat[SW-1], wet_sat};
  assign mix_rnd = mix_sum + $signed({{SW{1'b0}}, mix_sum[SW]});

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.emit) begin
      out_q <= mix_rnd[SW:1];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

// ===== hdl/mted_checker.sv =====
// ----------------------------------------------------------------------------
// mted_checker: port-level checks for the multi-tap echo delay
// Tracks transfers in flight and checks ordering against the port handshakes.
// ----------------------------------------------------------------------------
module mted_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [mted_pkg::SAMPLE_W-1:0] sample_out_o
);

  // Samples taken in but not yet delivered
  logic [1:0] pend_q, pend_d;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_valid_o & ~out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled result changed or dropped");

  // One sample at a time: input closes right after a transfer
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open in the cycle after a transfer");

  // A new result comes from a busy cycle, never straight from idle
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without processing");

  // No result without a sample behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending sample");

  // At most one sample in work plus one held result
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many samples in flight");

endmodule

bind multi_tap_echo_delay mted_checker u_mted_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for multi_tap_echo_delay
// Drives samples and register writes, predicts every mixed output sample
// from a local copy of the delay line and registers, and compares each
// output transfer in order. Random idle bursts sit on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int LINE_LEN     = mted_pkg::DEPTH_DEF;
  localparam int TAP_CAP      = mted_pkg::MAX_TAPS_DEF;
  localparam int STALL_LIMIT  = 6000;
  localparam int DRAIN_CYCLES = 500;

  typedef logic signed [mted_pkg::SAMPLE_W-1:0] sample_t;

  // Predicts the mixed output and holds the results still owed by the DUT
  class echo_checker;
    sample_t     line [LINE_LEN];
    int unsigned wr_idx;
    int unsigned spacing;
    int unsigned count;
    bit          alt;
    bit          lin;
    sample_t     mix_due [$];
    int          failures;
    int          reported;

    function new();
      foreach (line[i]) line[i] = '0;
      wr_idx   = 0;
      spacing  = mted_pkg::SPACING_RST;
      count    = mted_pkg::COUNT_RST;
      alt      = 1'b0;
      lin      = 1'b0;
      failures = 0;
      reported = 0;
    endfunction

    function void set_reg(logic [mted_pkg::REG_IDX_W-1:0] idx,
                          logic [mted_pkg::PDATA_W-1:0] val);
      case (idx)
        mted_pkg::REG_TAP_SPACING:    spacing = val[mted_pkg::SPACING_W-1:0];
        mted_pkg::REG_TAP_COUNT:      count   = val[mted_pkg::COUNT_W-1:0];
        mted_pkg::REG_ALT_POLARITY:   alt     = val[0];
        mted_pkg::REG_LINEAR_DIVISOR: lin     = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return mix_due.size();
    endfunction

    // Accepted input sample: form wet sum, queue the mix, store the sample
    function void take_sample(sample_t x);
      longint      wet;
      longint      tap;
      longint      mix;
      int unsigned taps;
      int unsigned dly;
      int unsigned k;
      taps = (count > TAP_CAP) ? TAP_CAP : count;
      wet  = 0;
      for (k = 1; k <= taps; k++) begin
        dly = k * spacing;
        // zero delay reads the current input, past the line reads zero
        if (dly == 0) tap = x;
        else if (dly > LINE_LEN) tap = 0;
        else tap = line[(wr_idx + LINE_LEN - dly) % LINE_LEN];
        if (alt && (k % 2 == 1)) tap = -tap;
        if (lin) wet += tap / longint'(k + 1);
        else wet += tap / (longint'(1) << k);
      end
      if (wet > longint'(mted_pkg::SAT_MAX)) wet = longint'(mted_pkg::SAT_MAX);
      else if (wet < longint'(mted_pkg::SAT_MIN)) wet = longint'(mted_pkg::SAT_MIN);
      mix = (longint'(x) + wet) / 2;
      mix_due.push_back(sample_t'(mix[mted_pkg::SAMPLE_W-1:0]));
      line[wr_idx] = x;
      wr_idx = (wr_idx + 1) % LINE_LEN;
    endfunction

    // Output transfer: compare against the oldest queued mix
    function void match_output(sample_t got);
      sample_t want;
      if (mix_due.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("tb: sample_out %0d with no result pending", got);
        end
        return;
      end
      want = mix_due.pop_front();
      if (got !== want) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("tb: sample_out mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  sample_t                       sample_in  = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  sample_t                       sample_out;
  logic                          psel       = 1'b0;
  logic                          penable    = 1'b0;
  logic                          pwrite     = 1'b0;
  logic [mted_pkg::PADDR_W-1:0]  paddr      = '0;
  logic [mted_pkg::PDATA_W-1:0]  pwdata     = '0;
  logic [mted_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  echo_checker board;
  int          gap_odds    = 0;
  int          stall_odds  = 0;
  int          idle_cycles = 0;

  multi_tap_echo_delay dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // APB write: setup, access, then a return to idle
  task automatic write_reg(input logic [mted_pkg::REG_IDX_W-1:0] idx,
                           input logic [mted_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for the block to drain, then load all four registers
  // (upper data bits carry noise; only the field bits count)
  task automatic configure(input int unsigned sp, input int unsigned cnt,
                           input bit alt_on, input bit lin_on);
    while (board.pending() != 0) @(posedge clk_i);
    write_reg(mted_pkg::REG_TAP_SPACING, {16'($urandom), 16'(sp)});
    write_reg(mted_pkg::REG_TAP_COUNT, {27'($urandom), 5'(cnt)});
    write_reg(mted_pkg::REG_ALT_POLARITY, {31'($urandom), alt_on});
    write_reg(mted_pkg::REG_LINEAR_DIVISOR, {31'($urandom), lin_on});
  endtask

  // One input transfer; valid stays high for a following sample
  task automatic push_sample(input sample_t x);
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk_i); while (in_stall);
    board.take_sample(x);
  endtask

  // Optional random gap on the input side
  task automatic rest_input();
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return mted_pkg::SAT_MAX;
      1:       return mted_pkg::SAT_MIN;
      2:       return sample_t'(int'($urandom_range(0, 16)) - 8);
      3:       return $urandom_range(0, 1) ? sample_t'(0) : sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_items(input int n);
    for (int i = 0; i < n; i++) begin
      push_sample(pick_sample());
      rest_input();
    end
    in_valid <= 1'b0;
  endtask

  task automatic run_list(input sample_t xs [$]);
    foreach (xs[i]) begin
      push_sample(xs[i]);
      rest_input();
    end
    in_valid <= 1'b0;
  endtask

  // Output side: random stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Output checking and watchdog on transfer activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) board.match_output(sample_out);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned sp;
    int unsigned cnt;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes under reset settings, then the corner settings
    gap_odds   = 4;
    stall_odds = 4;
    run_list('{mted_pkg::SAT_MAX, mted_pkg::SAT_MIN, sample_t'(0), sample_t'(-1),
               sample_t'(1), sample_t'(-2)});
    // zero spacing: all taps read the current input, linear sum saturates
    configure(0, 16, 1'b0, 1'b1);
    run_list('{mted_pkg::SAT_MAX, mted_pkg::SAT_MIN, sample_t'(5), sample_t'(-5)});
    configure(0, 16, 1'b1, 1'b0);
    run_list('{mted_pkg::SAT_MAX, mted_pkg::SAT_MIN, sample_t'(7)});
    configure(0, 16, 1'b1, 1'b1);
    run_list('{mted_pkg::SAT_MAX, mted_pkg::SAT_MIN});
    // no taps: dry halving, truncated toward zero
    configure(1, 0, 1'b0, 0);
    run_list('{mted_pkg::SAT_MAX, mted_pkg::SAT_MIN, sample_t'(-1), sample_t'(1)});
    // tap count above the cap
    configure(1, 31, 1'b1, 1'b1);
    run_list('{mted_pkg::SAT_MAX, mted_pkg::SAT_MIN, sample_t'(3), mted_pkg::SAT_MAX});
    // every tap past the end of the line
    configure(16'hffff, 2, 1'b0, 1'b0);
    run_list('{mted_pkg::SAT_MAX, mted_pkg::SAT_MIN});

    // A tap at exactly the line length reads the zeros left by reset
    gap_odds   = 24;
    stall_odds = 24;
    configure(LINE_LEN, 1, 1'($urandom_range(0, 1)), 1'b0);
    run_items(100);

    // Line-length boundaries; these taps reach past the samples written so far and read zero
    gap_odds   = 6;
    stall_odds = 6;
    configure(LINE_LEN / 2, 2, 1'b1, 1'b1);
    run_items(20);
    configure(LINE_LEN / TAP_CAP, TAP_CAP, 1'b0, 1'b0);
    run_items(20);
    configure(LINE_LEN + 1, 1, 1'b0, 1'b1);
    run_items(10);

    // Random settings; the last phases run without idling
    for (int p = 0; p < 10; p++) begin
      if (p >= 8) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(0, 1) ? 0 : $urandom_range(2, 8);
        stall_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 8);
      end
      case ($urandom_range(0, 9))
        0:       sp = 0;
        1:       sp = $urandom_range(LINE_LEN, 65535);
        2:       sp = $urandom_range(1024, LINE_LEN);
        default: sp = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 7))
        0:       cnt = $urandom_range(TAP_CAP + 1, 31);
        1:       cnt = 0;
        default: cnt = $urandom_range(1, TAP_CAP);
      endcase
      configure(sp, cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_items($urandom_range(80, 120));
    end

    // Drain, then watch for stray results
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
